@@ sv/particle_pool_update_defines.svh @@
// Assertion macros used by the checker file.
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH

// same-cycle implication
`define PPU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppu check failed");

// next-cycle implication
`define PPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppu check failed");

`endif

@@ sv/ppu_pkg.sv @@
package ppu_pkg;

   localparam int CNT_OUT_W = 11;
   localparam int THR_W     = 11;
   localparam logic [THR_W-1:0] THR_RESET = 11'd100;

   localparam logic [1:0] REQ_CREATE  = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_COMPACT = 2'd2;
   localparam logic [1:0] REQ_READ    = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;

   localparam logic [2:0] ADDR_THR = 3'd0;

   typedef struct packed {
      logic             alive;
      logic [31:0]      life;
      logic [2:0][31:0] pos;
      logic [2:0][15:0] dir;
      logic [31:0]      speed;
   } slot_type;

   typedef struct packed {
      logic a_en;
      logic b_en;
   } move_ctl_type;

endpackage

@@ sv/ppu_store.sv @@
module ppu_store
   import ppu_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  slot_type      wdata,
   input  logic [AW-1:0] raddr,
   output slot_type      rdata
);

   slot_type mem [DEPTH];
   slot_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/ppu_axis.sv @@
module ppu_axis
   import ppu_pkg::*;
(
   input  logic         clock,
   input  move_ctl_type ctl,
   input  logic [15:0]  dir,
   input  logic [31:0]  speed,
   input  logic [15:0]  dt,
   input  logic [31:0]  pos,
   output logic [31:0]  moved
);

   logic [47:0] p1_ff;
   logic [63:0] p2_ff;
   logic        neg_ff;
   logic [15:0] mag;
   logic [35:0] delta;
   logic [35:0] sum;

   // |dir|; the most negative code maps to 0x8000 unsigned
   assign mag = dir[15] ? 16'(-dir) : dir;

   always_ff @(posedge clock) begin
      if (ctl.a_en) begin
         p1_ff  <= {32'b0, mag} * {16'b0, speed};
         neg_ff <= dir[15];
      end
      if (ctl.b_en) begin
         p2_ff <= {16'b0, p1_ff} * {48'b0, dt};
      end
   end

   // 46 fraction bits down to 16: truncate magnitude, then apply sign
   assign delta = neg_ff ? 36'(-{2'b0, p2_ff[63:30]}) : {2'b0, p2_ff[63:30]};
   assign sum   = {{4{pos[31]}}, pos} + delta;

   always_comb begin
      if ($signed(sum) > 36'sd2147483647) begin
         moved = 32'h7FFF_FFFF;
      end else if ($signed(sum) < -36'sd2147483648) begin
         moved = 32'h8000_0000;
      end else begin
         moved = sum[31:0];
      end
   end

endmodule

@@ sv/particle_pool_update.sv @@
// Channel   Handshake                     Beat
// request   start in, busy out            req_type + create/tick/read fields
// result    rsp_valid out, no back-press  status, counts, read slot fields
// config    APB psel/penable/pwrite       compact_threshold at byte 0
//
// Create: result the next cycle; busy stays low.
// Read: the slot memory read is registered, then the result registers load.
// Tick: states TK_RD, TK_A, TK_B, TK_C per live slot, TK_RD and TK_A per dead
//   slot; the registered memory read and the two-stage multiply set this.
// Compact: per used slot CP_RD reads, then CP_EV conditionally writes.
// Reset clears counters and control only; slot memory needs no clearing.
// The result strobe lasts one cycle and the receiver cannot stall it.
module particle_pool_update
   import ppu_pkg::*;
#(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [30:0]          req_life_ms,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic signed [15:0]   req_dir_x,
   input  logic signed [15:0]   req_dir_y,
   input  logic signed [15:0]   req_dir_z,
   input  logic [31:0]          req_speed,
   input  logic [15:0]          req_elapsed_ms,
   input  logic [15:0]          req_step_time,
   input  logic [9:0]           req_entry_index,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [10:0]          rsp_particle_count,
   output logic [10:0]          rsp_dead_count,
   output logic                 rsp_rd_alive,
   output logic signed [31:0]   rsp_rd_life,
   output logic signed [31:0]   rsp_rd_pos_x,
   output logic signed [31:0]   rsp_rd_pos_y,
   output logic signed [31:0]   rsp_rd_pos_z,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);

   typedef enum logic [2:0] {
      IDLE, TK_RD, TK_A, TK_B, TK_C, CP_RD, CP_EV, RD_WAIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     wptr_ff, wptr_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     dead_ff, dead_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [15:0]       el_ff, el_in;
   logic [15:0]       dt_ff, dt_in;
   slot_type          work_ff, work_in;
   logic [31:0]       life_new_ff, life_new_in;
   logic              died_ff, died_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rd_alive_ff, rd_alive_in;
   logic [31:0]       rd_life_ff, rd_life_in;
   logic [2:0][31:0]  rd_pos_ff, rd_pos_in;

   logic              accept;
   logic              cfg_write;
   logic [CW-1:0]     idx_next;
   logic              last_slot;
   logic [31:0]       life_sub;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   slot_type          mem_wdata;
   slot_type          mem_rdata;
   slot_type          new_slot;
   move_ctl_type      move_ctl;
   logic [2:0][31:0]  moved;

   assign busy      = (state_ff != IDLE);
   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr == ADDR_THR) ? {{(32-THR_W){1'b0}}, thr_ff} : 32'b0;

   assign idx_next  = idx_ff + 1'b1;
   assign last_slot = (idx_next >= used_ff);
   assign life_sub  = mem_rdata.life - {16'b0, el_ff};

   always_comb begin
      new_slot.alive = 1'b1;
      new_slot.life  = {1'b0, req_life_ms};
      new_slot.pos   = {req_pos_z, req_pos_y, req_pos_x};
      new_slot.dir   = {req_dir_z, req_dir_y, req_dir_x};
      new_slot.speed = req_speed;
   end

   ppu_store #(
      .DEPTH (POOL_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // one multiply lane per axis; speed shared, dir per axis
   for (genvar k = 0; k < 3; k++) begin : g_axis
      ppu_axis u_axis (
         .clock (clock),
         .ctl   (move_ctl),
         .dir   (mem_rdata.dir[k]),
         .speed (mem_rdata.speed),
         .dt    (dt_ff),
         .pos   (work_ff.pos[k]),
         .moved (moved[k])
      );
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      wptr_in       = wptr_ff;
      used_in       = used_ff;
      dead_in       = dead_ff;
      thr_in        = thr_ff;
      el_in         = el_ff;
      dt_in         = dt_ff;
      work_in       = work_ff;
      life_new_in   = life_new_ff;
      died_in       = died_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rd_alive_in   = rd_alive_ff;
      rd_life_in    = rd_life_ff;
      rd_pos_in     = rd_pos_ff;
      mem_we        = 1'b0;
      mem_waddr     = used_ff[AW-1:0];
      mem_wdata     = new_slot;
      mem_raddr     = idx_ff[AW-1:0];
      move_ctl      = '0;

      if (cfg_write && paddr == ADDR_THR) begin
         thr_in = pwdata[THR_W-1:0];
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               rd_alive_in   = 1'b0;
               rd_life_in    = '0;
               rd_pos_in     = '0;
               rsp_status_in = ST_DONE;
               idx_in        = '0;
               wptr_in       = '0;
               unique case (req_type)
                  REQ_CREATE: begin
                     rsp_valid_in = 1'b1;
                     if (32'(used_ff) >= POOL_DEPTH) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        used_in = used_ff + 1'b1;
                     end
                  end
                  REQ_TICK: begin
                     el_in = req_elapsed_ms;
                     dt_in = req_step_time;
                     if (used_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = TK_RD;
                     end
                  end
                  REQ_COMPACT: begin
                     if (32'(dead_ff) < 32'(thr_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_SKIP;
                     end else if (used_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        dead_in      = '0;
                     end else begin
                        state_in = CP_RD;
                     end
                  end
                  REQ_READ: begin
                     mem_raddr = AW'(req_entry_index);
                     hit_in    = (32'(req_entry_index) < 32'(used_ff));
                     state_in  = RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end

         TK_RD: state_in = TK_A;

         TK_A: begin
            if (mem_rdata.alive) begin
               work_in     = mem_rdata;
               life_new_in = life_sub;
               died_in     = ($signed(life_sub) <= 32'sd0);
               move_ctl.a_en = 1'b1;
               state_in    = TK_B;
            end else begin
               idx_in = idx_next;
               if (last_slot) begin
                  rsp_valid_in = 1'b1;
                  state_in     = IDLE;
               end else begin
                  state_in = TK_RD;
               end
            end
         end

         TK_B: begin
            move_ctl.b_en = 1'b1;
            state_in      = TK_C;
         end

         TK_C: begin
            mem_we         = 1'b1;
            mem_waddr      = idx_ff[AW-1:0];
            mem_wdata      = work_ff;
            mem_wdata.life = life_new_ff;
            if (died_ff) begin
               mem_wdata.alive = 1'b0;
               dead_in         = dead_ff + 1'b1;
            end else begin
               mem_wdata.pos = moved;
            end
            idx_in = idx_next;
            if (last_slot) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               state_in = TK_RD;
            end
         end

         CP_RD: state_in = CP_EV;

         CP_EV: begin
            mem_waddr = wptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            if (mem_rdata.alive) begin
               mem_we  = (wptr_ff != idx_ff);
               wptr_in = wptr_ff + 1'b1;
            end
            idx_in = idx_next;
            if (last_slot) begin
               used_in      = mem_rdata.alive ? wptr_ff + 1'b1 : wptr_ff;
               dead_in      = '0;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               state_in = CP_RD;
            end
         end

         RD_WAIT: begin
            rsp_valid_in = 1'b1;
            if (hit_ff) begin
               rd_alive_in = mem_rdata.alive;
               rd_life_in  = mem_rdata.life;
               rd_pos_in   = mem_rdata.pos;
            end
            state_in = IDLE;
         end

         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         used_ff      <= '0;
         dead_ff      <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         dead_ff      <= dead_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      wptr_ff       <= wptr_in;
      el_ff         <= el_in;
      dt_ff         <= dt_in;
      work_ff       <= work_in;
      life_new_ff   <= life_new_in;
      died_ff       <= died_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rd_alive_ff   <= rd_alive_in;
      rd_life_ff    <= rd_life_in;
      rd_pos_ff     <= rd_pos_in;
   end

   // counters settle at the same edge that raises the strobe
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_particle_count = CNT_OUT_W'(used_ff);
   assign rsp_dead_count     = CNT_OUT_W'(dead_ff);
   assign rsp_rd_alive       = rd_alive_ff;
   assign rsp_rd_life        = rd_life_ff;
   assign rsp_rd_pos_x       = rd_pos_ff[0];
   assign rsp_rd_pos_y       = rd_pos_ff[1];
   assign rsp_rd_pos_z       = rd_pos_ff[2];

endmodule

@@ sv/ppu_checker.sv @@
`include "particle_pool_update_defines.svh"

module ppu_checker
   import ppu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [10:0] rsp_particle_count,
   input logic [10:0] rsp_dead_count,
   input logic        rsp_rd_alive
);

   `PPU_ASSERT_NEXT(a_create_answers, clock, reset, start && !busy && req_type == REQ_CREATE, rsp_valid)
   `PPU_ASSERT_NOW(a_strobe_when_free, clock, reset, rsp_valid, !busy)
   `PPU_ASSERT_NOW(a_dead_le_used, clock, reset, rsp_valid, rsp_dead_count <= rsp_particle_count)
   `PPU_ASSERT_NOW(a_alive_only_done, clock, reset, rsp_valid && rsp_status != ST_DONE, !rsp_rd_alive)

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (.*);
